// File: hdl/tpp_pkg.sv
`timescale 1ns / 1ps

package tpp_pkg;

  localparam int AddrWidth = 5;
  localparam int DataWidth = 32;

  localparam logic [7:0] RadiusReset = 8'd120;
  localparam logic [7:0] PixMax      = 8'd255;
  localparam logic [7:0] PixMin      = 8'd0;

  typedef enum logic [2:0] {
    REG_CENTER_LAT = 3'd0,
    REG_CENTER_LON = 3'd1,
    REG_LAT_SCALE  = 3'd2,
    REG_LON_SCALE  = 3'd3,
    REG_RADIUS_PX  = 3'd4
  } tpp_reg_e;

  typedef struct packed {
    logic signed [30:0] latitude;
    logic signed [31:0] longitude;
    logic               point_valid;
    logic               new_track;
  } tpp_in_t;

  typedef struct packed {
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [7:0] box_min_x;
    logic [7:0] box_max_x;
    logic [7:0] box_min_y;
    logic [7:0] box_max_y;
  } tpp_out_t;

  typedef struct packed {
    logic signed [30:0] center_lat;
    logic signed [31:0] center_lon;
    logic [31:0]        lat_scale;
    logic [31:0]        lon_scale;
    logic [7:0]         radius_px;
  } tpp_cfg_t;

  // scaled magnitudes, 32x32 exact
  typedef struct packed {
    logic [63:0] lat_prod;
    logic [63:0] lon_prod;
    logic        lat_neg;
    logic        lon_neg;
    logic        point_valid;
    logic        new_track;
  } tpp_prod_t;

endpackage

// File: hdl/tpp_regs.sv
`timescale 1ns / 1ps

module tpp_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpp_pkg::AddrWidth-1:0] paddr,
  input  logic [tpp_pkg::DataWidth-1:0] pwdata,
  output logic [tpp_pkg::DataWidth-1:0] prdata,
  output logic                          pready,
  output tpp_pkg::tpp_cfg_t             cfg_o
);
  import tpp_pkg::*;

  tpp_cfg_t cfg_q;
  tpp_reg_e reg_idx;
  logic     wr;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_idx = tpp_reg_e'(paddr[AddrWidth-1:2]);
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_lat <= '0;
      cfg_q.center_lon <= '0;
      cfg_q.lat_scale  <= '0;
      cfg_q.lon_scale  <= '0;
      cfg_q.radius_px  <= RadiusReset;
    end else if (wr) begin
      unique case (reg_idx)
        REG_CENTER_LAT: cfg_q.center_lat <= pwdata[30:0];
        REG_CENTER_LON: cfg_q.center_lon <= pwdata;
        REG_LAT_SCALE:  cfg_q.lat_scale  <= pwdata;
        REG_LON_SCALE:  cfg_q.lon_scale  <= pwdata;
        REG_RADIUS_PX:  cfg_q.radius_px  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CENTER_LAT: prdata = {cfg_q.center_lat[30], cfg_q.center_lat};
      REG_CENTER_LON: prdata = cfg_q.center_lon;
      REG_LAT_SCALE:  prdata = cfg_q.lat_scale;
      REG_LON_SCALE:  prdata = cfg_q.lon_scale;
      REG_RADIUS_PX:  prdata = {24'd0, cfg_q.radius_px};
      default:        prdata = '0;
    endcase
  end

endmodule

// File: hdl/tpp_scale.sv
`timescale 1ns / 1ps

module tpp_scale (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  tpp_pkg::tpp_in_t   in_data_i,
  output logic               in_stall_o,
  input  tpp_pkg::tpp_cfg_t  cfg_i,
  input  logic               adv_i,
  output logic               prod_valid_o,
  output tpp_pkg::tpp_prod_t prod_o
);
  import tpp_pkg::*;

  logic [31:0] lat_diff, lat_negd, lat_mag;
  logic [32:0] lon_diff, lon_negd;
  logic [31:0] lon_mag;
  logic        lat_neg, lon_neg;

  logic        s0_v_q, s1_v_q;
  logic [31:0] s0_lat_mag_q, s0_lon_mag_q;
  logic        s0_lat_neg_q, s0_lon_neg_q, s0_pv_q, s0_nt_q;
  tpp_prod_t   s1_q;
  logic        en0, en1;

  // center subtract and magnitude
  assign lat_diff = {in_data_i.latitude[30], in_data_i.latitude}
                  - {cfg_i.center_lat[30], cfg_i.center_lat};
  assign lon_diff = {in_data_i.longitude[31], in_data_i.longitude}
                  - {cfg_i.center_lon[31], cfg_i.center_lon};
  assign lat_neg  = lat_diff[31];
  assign lon_neg  = lon_diff[32];
  assign lat_negd = ~lat_diff + 32'd1;
  assign lon_negd = ~lon_diff + 33'd1;
  assign lat_mag  = lat_neg ? lat_negd : lat_diff;
  assign lon_mag  = lon_neg ? lon_negd[31:0] : lon_diff[31:0];

  assign en1 = !s1_v_q || adv_i;
  assign en0 = !s0_v_q || en1;
  assign in_stall_o = !en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
    end else begin
      if (en0) s0_v_q <= in_valid_i;
      if (en1) s1_v_q <= s0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0 && in_valid_i) begin
      s0_lat_mag_q <= lat_mag;
      s0_lon_mag_q <= lon_mag;
      s0_lat_neg_q <= lat_neg;
      s0_lon_neg_q <= lon_neg;
      s0_pv_q      <= in_data_i.point_valid;
      s0_nt_q      <= in_data_i.new_track;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && s0_v_q) begin
      s1_q.lat_prod    <= s0_lat_mag_q * cfg_i.lat_scale;
      s1_q.lon_prod    <= s0_lon_mag_q * cfg_i.lon_scale;
      s1_q.lat_neg     <= s0_lat_neg_q;
      s1_q.lon_neg     <= s0_lon_neg_q;
      s1_q.point_valid <= s0_pv_q;
      s1_q.new_track   <= s0_nt_q;
    end
  end

  assign prod_valid_o = s1_v_q;
  assign prod_o       = s1_q;

endmodule

// File: hdl/tpp_plot.sv
`timescale 1ns / 1ps

module tpp_plot #(
  parameter int COORD_FRAC_BITS = 23,
  parameter int MIN_STEP_PX     = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               prod_valid_i,
  input  tpp_pkg::tpp_prod_t prod_i,
  input  logic [7:0]         radius_i,
  output logic               take_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tpp_pkg::tpp_out_t  out_data_o
);
  import tpp_pkg::*;

  localparam int Shift   = COORD_FRAC_BITS + 8;
  localparam int IpWidth = 64 - Shift;
  localparam logic [7:0] Step = 8'(MIN_STEP_PX);

  typedef struct packed {
    logic       ok;
    logic [7:0] pix;
  } tpp_place_t;

  function automatic tpp_place_t place(input logic [63:0] prod, input logic sub,
                                       input logic [7:0] r);
    logic [IpWidth-1:0] ip;
    logic               frac;
    logic [8:0]         room;
    tpp_place_t         res;
    ip      = prod[63:Shift];
    frac    = |prod[Shift-1:0];
    room    = sub ? {1'b0, r} : (9'd255 - {1'b0, r});
    res.ok  = !((ip > IpWidth'(room)) || ((ip == IpWidth'(room)) && frac));
    res.pix = sub ? (r - ip[7:0] - {7'd0, frac}) : (r + ip[7:0]);
    return res;
  endfunction

  logic [7:0] last_x_q, last_y_q, min_x_q, max_x_q, min_y_q, max_y_q;
  logic [7:0] b_last_x, b_last_y, b_min_x, b_max_x, b_min_y, b_max_y;
  logic [7:0] n_min_x, n_max_x, n_min_y, n_max_y, dx, dy;
  tpp_place_t px, py;
  logic       emit, take;
  logic       out_valid_q;
  tpp_out_t   out_q;

  assign take_o = !out_valid_q || !out_stall_i;
  assign take   = prod_valid_i && take_o;

  always_comb begin
    if (prod_i.new_track) begin
      b_last_x = PixMax; b_last_y = PixMax;
      b_min_x  = PixMax; b_max_x  = PixMin;
      b_min_y  = PixMax; b_max_y  = PixMin;
    end else begin
      b_last_x = last_x_q; b_last_y = last_y_q;
      b_min_x  = min_x_q;  b_max_x  = max_x_q;
      b_min_y  = min_y_q;  b_max_y  = max_y_q;
    end
    px = place(prod_i.lon_prod, prod_i.lon_neg, radius_i);
    py = place(prod_i.lat_prod, !prod_i.lat_neg, radius_i);
    dx = (px.pix > b_last_x) ? (px.pix - b_last_x) : (b_last_x - px.pix);
    dy = (py.pix > b_last_y) ? (py.pix - b_last_y) : (b_last_y - py.pix);
    emit = prod_i.point_valid && px.ok && py.ok && ((dx > Step) || (dy > Step));
    n_min_x = (px.pix < b_min_x) ? px.pix : b_min_x;
    n_max_x = (px.pix > b_max_x) ? px.pix : b_max_x;
    n_min_y = (py.pix < b_min_y) ? py.pix : b_min_y;
    n_max_y = (py.pix > b_max_y) ? py.pix : b_max_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q    <= PixMax;
      last_y_q    <= PixMax;
      min_x_q     <= PixMax;
      max_x_q     <= PixMin;
      min_y_q     <= PixMax;
      max_y_q     <= PixMin;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        if (emit) begin
          last_x_q <= px.pix;  last_y_q <= py.pix;
          min_x_q  <= n_min_x; max_x_q  <= n_max_x;
          min_y_q  <= n_min_y; max_y_q  <= n_max_y;
        end else begin
          last_x_q <= b_last_x; last_y_q <= b_last_y;
          min_x_q  <= b_min_x;  max_x_q  <= b_max_x;
          min_y_q  <= b_min_y;  max_y_q  <= b_max_y;
        end
      end
      if (take && emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      out_q.pixel_x   <= px.pix;
      out_q.pixel_y   <= py.pix;
      out_q.box_min_x <= n_min_x;
      out_q.box_max_x <= n_max_x;
      out_q.box_min_y <= n_min_y;
      out_q.box_max_y <= n_max_y;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hdl/track_pixel_projector_unit.sv
`timescale 1ns / 1ps

// Track pixel projector: takes one GPS point word per clock unless stalled
// and may present one pixel word (point position plus the running bounding
// box). Throughput is one word per cycle absent output stalls, set by the
// subtract/abs stage, the two 32x32 multipliers and the placement stage that
// owns the last-pixel and box registers. Three words can be in flight, so the
// input keeps accepting until those stages fill behind a stalled output. The
// user writes configuration (center, scales, radius) over the APB port while
// no word is in flight (not enforced); register i sits at byte address 4*i.

module track_pixel_projector_unit #(
  parameter int COORD_FRAC_BITS = 23,
  parameter int MIN_STEP_PX     = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  tpp_pkg::tpp_in_t              in_data_i,
  output logic                          in_stall_o,
  output logic                          out_valid_o,
  output tpp_pkg::tpp_out_t             out_data_o,
  input  logic                          out_stall_i,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpp_pkg::AddrWidth-1:0] paddr,
  input  logic [tpp_pkg::DataWidth-1:0] pwdata,
  output logic [tpp_pkg::DataWidth-1:0] prdata,
  output logic                          pready
);
  import tpp_pkg::*;

  tpp_cfg_t  cfg;
  tpp_prod_t prod;
  logic      prod_valid, take;

  tpp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tpp_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .in_stall_o   (in_stall_o),
    .cfg_i        (cfg),
    .adv_i        (take),
    .prod_valid_o (prod_valid),
    .prod_o       (prod)
  );

  tpp_plot #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .MIN_STEP_PX     (MIN_STEP_PX)
  ) u_plot (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .prod_valid_i (prod_valid),
    .prod_i       (prod),
    .radius_i     (cfg.radius_px),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

// File: hdl/tpp_checker.sv
`timescale 1ns / 1ps

module tpp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input tpp_pkg::tpp_out_t out_data_o,
  input logic              out_stall_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");

  a_box_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.box_min_x <= out_data_o.pixel_x) &&
                    (out_data_o.pixel_x <= out_data_o.box_max_x))
    else $error("pixel_x outside box");

  a_box_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.box_min_y <= out_data_o.pixel_y) &&
                    (out_data_o.pixel_y <= out_data_o.box_max_y))
    else $error("pixel_y outside box");

  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

bind track_pixel_projector_unit tpp_checker u_tpp_checker (.*);
